### rtl/lbc_pkg.sv
package lbc_pkg;

  localparam int FIELD_W = 16;
  localparam int IN_CH = 3;
  localparam int TDATA_W = 64;
  localparam int TUSER_W = 6;
  localparam int MODE_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR       = 5'd0,
    MODE_SOURCE      = 5'd1,
    MODE_OVER        = 5'd2,
    MODE_IN          = 5'd3,
    MODE_OUT         = 5'd4,
    MODE_ATOP        = 5'd5,
    MODE_DEST        = 5'd6,
    MODE_DEST_OVER   = 5'd7,
    MODE_DEST_IN     = 5'd8,
    MODE_DEST_OUT    = 5'd9,
    MODE_DEST_ATOP   = 5'd10,
    MODE_XOR         = 5'd11,
    MODE_ADD         = 5'd12,
    MODE_SATURATE    = 5'd13,
    MODE_MULTIPLY    = 5'd14,
    MODE_SCREEN      = 5'd15,
    MODE_OVERLAY     = 5'd16,
    MODE_DARKEN      = 5'd17,
    MODE_LIGHTEN     = 5'd18,
    MODE_COLOR_DODGE = 5'd19,
    MODE_COLOR_BURN  = 5'd20,
    MODE_HARD_LIGHT  = 5'd21,
    MODE_SOFT_LIGHT  = 5'd22,
    MODE_DIFFERENCE  = 5'd23,
    MODE_EXCLUSION   = 5'd24
  } mode_e;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } ds_req_t;

endpackage

### rtl/lbc_divsqrt.sv
module lbc_divsqrt #(
  parameter int FRAC_BITS = 15
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lbc_pkg::ds_req_t       req_i,
  input  logic [2*FRAC_BITS+1:0] num_i,
  input  logic [FRAC_BITS:0]     den_i,
  output logic                   done_o,
  output logic [FRAC_BITS:0]     res_o
);

  localparam int N = FRAC_BITS;
  localparam int VW = N + 1;
  localparam int SW = 2 * N + 2;
  localparam int RW = N + 4;
  localparam int QW = N + 2;
  localparam int CW = $clog2(N + 3);
  localparam logic [VW-1:0] ONE = VW'(1) << N;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic          sqrt_q, sqrt_d;
  logic          sat_q, sat_d;
  logic          zero_q, zero_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] sh_q, sh_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [QW-1:0] res_q, res_d;
  logic [VW-1:0] den_q, den_d;

  logic [N-1:0]  hi;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] sub_op;
  logic [RW:0]   diff;
  logic          ge;
  logic [QW-1:0] root_rnd;

  assign hi = num_i[SW-1:N+2];

  always_comb begin
    rem_sh = sqrt_q ? {rem_q[RW-3:0], sh_q[SW-1:SW-2]} : {rem_q[RW-2:0], sh_q[SW-1]};
    sub_op = sqrt_q ? RW'({res_q, 2'b01}) : RW'(den_q);
    diff   = {1'b0, rem_sh} - {1'b0, sub_op};
    ge     = ~diff[RW];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sqrt_d = sqrt_q;
    sat_d  = sat_q;
    zero_d = zero_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    res_d  = res_q;
    den_d  = den_q;
    if (busy_q) begin
      rem_d = ge ? diff[RW-1:0] : rem_sh;
      res_d = {res_q[QW-2:0], ge};
      sh_d  = sqrt_q ? (sh_q << 2) : (sh_q << 1);
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      sqrt_d = req_i.is_sqrt;
      den_d  = den_i;
      res_d  = '0;
      if (req_i.is_sqrt) begin
        sh_d   = num_i;
        rem_d  = '0;
        cnt_d  = CW'(N + 1);
        sat_d  = 1'b0;
        zero_d = 1'b0;
      end else begin
        sh_d   = {num_i[N+1:0], {N{1'b0}}};
        rem_d  = RW'(hi);
        cnt_d  = CW'(N + 2);
        sat_d  = ({1'b0, hi} >= den_i);
        zero_d = (den_i == '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sqrt_q <= sqrt_d;
    sat_q  <= sat_d;
    zero_q <= zero_d;
    cnt_q  <= cnt_d;
    sh_q   <= sh_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    den_q  <= den_d;
  end

  // round root to nearest, saturate quotient at one
  assign root_rnd = (rem_q > RW'(res_q)) ? res_q + QW'(1) : res_q;

  always_comb begin
    if (sqrt_q) begin
      res_o = VW'(root_rnd);
    end else if (zero_q) begin
      res_o = '0;
    end else if (sat_q || (res_q > QW'(ONE))) begin
      res_o = ONE;
    end else begin
      res_o = res_q[VW-1:0];
    end
  end

  assign done_o = done_q;

endmodule

### rtl/layer_blend_compositor.sv
// first layer: the accumulator loads directly
// blend layer: alpha states AL1, AL2, AL3 and ALR, then per channel multiply or rounding states,
//   divides or square roots on the shared unit and a write state
//   (result-alpha divide, one more pass for dodge, burn and soft light)
// last layer: then an output wait and an OUT step per channel to a registered result; one item at a time
// async active-low reset clears the control state and the accumulator to zero
module layer_blend_compositor #(
  parameter int CHANNELS = 3,
  parameter int FRAC_BITS = 15
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // channel_0, channel_1, channel_2, alpha_in
  input  logic [lbc_pkg::TDATA_W-1:0] s_axis_tdata_i,
  // blend_mode, first_layer
  input  logic [lbc_pkg::TUSER_W-1:0] s_axis_tuser_i,
  input  logic                        s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // out_channel_0, out_channel_1, out_channel_2, out_alpha
  output logic [lbc_pkg::TDATA_W-1:0] m_axis_tdata_o
);

  localparam int N = FRAC_BITS;
  localparam int VW = N + 1;
  localparam int SW = 2 * N + 2;
  localparam int MW = N + 4;
  localparam int PW = MW + VW;
  localparam int PW1 = PW + 1;
  localparam int UW = N + 3;
  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int FW = lbc_pkg::FIELD_W;
  localparam int IW = (VW > FW) ? VW : FW;

  localparam logic [VW-1:0]  ONE = VW'(1) << N;
  localparam logic [VW-1:0]  HALF = VW'(1) << (N - 1);
  localparam logic [VW-1:0]  QUARTER = VW'(1) << (N - 2);
  localparam logic [PW1-1:0] HALF_P = PW1'(1) << (N - 1);
  localparam logic [SW-1:0]  HALF_S = SW'(1) << (N - 1);
  localparam logic [SW-1:0]  ONE_S = SW'(ONE);
  localparam logic [MW-1:0]  ONE_M = MW'(ONE);
  localparam logic [MW-1:0]  FOUR_M = MW'(4) << N;
  localparam logic [MW-1:0]  TWELVE_M = MW'(12) << N;
  localparam logic [CHW-1:0] LAST_CH = CHW'(CHANNELS - 1);

  typedef enum logic [16:0] {
    ST_IDLE  = 17'b1 << 0,
    ST_AL1   = 17'b1 << 1,
    ST_AL2   = 17'b1 << 2,
    ST_AL3   = 17'b1 << 3,
    ST_ALR   = 17'b1 << 4,
    ST_F1    = 17'b1 << 5,
    ST_F2    = 17'b1 << 6,
    ST_F3    = 17'b1 << 7,
    ST_FDIV  = 17'b1 << 8,
    ST_N1    = 17'b1 << 9,
    ST_N2    = 17'b1 << 10,
    ST_N3    = 17'b1 << 11,
    ST_NFIN  = 17'b1 << 12,
    ST_VDIV  = 17'b1 << 13,
    ST_WR    = 17'b1 << 14,
    ST_OWAIT = 17'b1 << 15,
    ST_OUT   = 17'b1 << 16
  } state_e;

  function automatic logic [VW-1:0] sat_s(input logic [SW-1:0] v);
    return (v > ONE_S) ? ONE : v[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] sat_in(input logic [FW-1:0] v);
    logic [IW-1:0] e;
    e = IW'(v);
    return (e > IW'(ONE)) ? ONE : VW'(e);
  endfunction

  function automatic logic is_pdf(input lbc_pkg::mode_e m);
    return m inside {[lbc_pkg::MODE_MULTIPLY:lbc_pkg::MODE_EXCLUSION]};
  endfunction

  function automatic logic is_div(input lbc_pkg::mode_e m);
    return is_pdf(m) || (m inside {lbc_pkg::MODE_OVER, lbc_pkg::MODE_DEST_OVER,
                                   lbc_pkg::MODE_XOR, lbc_pkg::MODE_ADD,
                                   lbc_pkg::MODE_SATURATE});
  endfunction

  function automatic logic is_round(input lbc_pkg::mode_e m);
    return m inside {lbc_pkg::MODE_ATOP, lbc_pkg::MODE_DEST_ATOP};
  endfunction

  function automatic state_e chan_start(input lbc_pkg::mode_e m);
    if (is_pdf(m)) begin
      return ST_F1;
    end else if (is_div(m) || is_round(m)) begin
      return ST_N1;
    end
    return ST_WR;
  endfunction

  state_e             state_q, state_d;
  logic [VW-1:0]      x_q [CHANNELS];
  logic [VW-1:0]      x_d [CHANNELS];
  logic [VW-1:0]      col_q [CHANNELS];
  logic [VW-1:0]      col_d [CHANNELS];
  logic [FW-1:0]      out_q [CHANNELS];
  logic [FW-1:0]      out_d [CHANNELS];
  logic [VW-1:0]      a_q, a_d;
  logic [VW-1:0]      alpha_q, alpha_d;
  lbc_pkg::mode_e     mode_q, mode_d;
  logic               last_q, last_d;
  logic [VW-1:0]      t1_q, t1_d, t2_q, t2_d, t3_q, t3_d;
  logic [VW-1:0]      r_q, r_d;
  logic [SW-1:0]      s_q, s_d;
  logic [UW-1:0]      u_q, u_d;
  logic [VW-1:0]      g_q, g_d;
  logic [VW-1:0]      f_q, f_d;
  logic [VW-1:0]      v_q, v_d;
  logic [CHW-1:0]     ch_q, ch_d;
  logic [FW-1:0]      out_alpha_q, out_alpha_d;
  logic               m_valid_q, m_valid_d;

  logic [VW-1:0]      xc, yc, xi, yi, ai, bi, t, e, dv, wval;
  logic [MW-1:0]      mul_a;
  logic [VW-1:0]      mul_b;
  logic [PW-1:0]      prod;
  logic [PW1-1:0]     prod_w, rnd_w, rnd2_w, ex_w;
  logic [VW-1:0]      rnd_v, h;
  logic               cond, gge;

  lbc_pkg::ds_req_t   ds_req;
  logic [SW-1:0]      ds_num;
  logic [VW-1:0]      ds_den;
  logic               ds_done;
  logic [VW-1:0]      ds_res;

  lbc_divsqrt #(
    .FRAC_BITS(FRAC_BITS)
  ) u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ds_req),
    .num_i  (ds_num),
    .den_i  (ds_den),
    .done_o (ds_done),
    .res_o  (ds_res)
  );

  assign xc = x_q[ch_q];
  assign yc = col_q[ch_q];
  assign xi = ONE - xc;
  assign yi = ONE - yc;
  assign ai = ONE - a_q;
  assign bi = ONE - alpha_q;

  // the shared multiplier
  assign prod   = PW'(mul_a) * PW'(mul_b);
  assign prod_w = PW1'(prod);
  assign rnd_w  = (prod_w + HALF_P) >> N;
  assign rnd2_w = ((prod_w << 1) + HALF_P) >> N;
  assign ex_w   = (((PW1'(xc) + PW1'(yc)) << N) - (prod_w << 1) + HALF_P) >> N;
  assign rnd_v  = rnd_w[VW-1:0];
  assign h      = sat_s(SW'(rnd2_w));
  assign t      = rnd_v;
  assign e      = (xc << 1) - ONE;
  assign gge    = (g_q >= yc);
  assign dv     = gge ? (g_q - yc) : (yc - g_q);

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    col_d       = col_q;
    out_d       = out_q;
    a_d         = a_q;
    alpha_d     = alpha_q;
    mode_d      = mode_q;
    last_d      = last_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    t3_d        = t3_q;
    r_d         = r_q;
    s_d         = s_q;
    u_d         = u_q;
    g_d         = g_q;
    f_d         = f_q;
    v_d         = v_q;
    ch_d        = ch_q;
    out_alpha_d = out_alpha_q;
    m_valid_d   = m_valid_q;
    mul_a       = '0;
    mul_b       = '0;
    ds_req      = '0;
    ds_num      = '0;
    ds_den      = '0;
    cond        = 1'b0;
    wval        = yc;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          for (int c = 0; c < CHANNELS; c++) begin
            x_d[c] = sat_in(s_axis_tdata_i[c*FW +: FW]);
          end
          a_d    = sat_in(s_axis_tdata_i[lbc_pkg::IN_CH*FW +: FW]);
          mode_d = lbc_pkg::mode_e'(s_axis_tuser_i[lbc_pkg::MODE_W-1:0]);
          last_d = s_axis_tlast_i;
          if (s_axis_tuser_i[lbc_pkg::MODE_W]) begin
            for (int c = 0; c < CHANNELS; c++) begin
              col_d[c] = sat_in(s_axis_tdata_i[c*FW +: FW]);
            end
            alpha_d = sat_in(s_axis_tdata_i[lbc_pkg::IN_CH*FW +: FW]);
            state_d = s_axis_tlast_i ? ST_OWAIT : ST_IDLE;
          end else begin
            state_d = ST_AL1;
          end
        end
      end
      ST_AL1: begin
        mul_a   = MW'(a_q);
        mul_b   = bi;
        t1_d    = rnd_v;
        s_d     = SW'(prod);
        state_d = ST_AL2;
      end
      ST_AL2: begin
        mul_a   = MW'(ai);
        mul_b   = alpha_q;
        t2_d    = rnd_v;
        s_d     = s_q + SW'(prod);
        state_d = ST_AL3;
      end
      ST_AL3: begin
        mul_a   = MW'(a_q);
        mul_b   = alpha_q;
        t3_d    = rnd_v;
        state_d = ST_ALR;
      end
      ST_ALR: begin
        case (mode_q) inside
          lbc_pkg::MODE_CLEAR:                             r_d = ai;
          lbc_pkg::MODE_SOURCE, lbc_pkg::MODE_DEST_ATOP:   r_d = a_q;
          lbc_pkg::MODE_IN, lbc_pkg::MODE_DEST_IN:         r_d = t3_q;
          lbc_pkg::MODE_OUT:                               r_d = t1_q;
          lbc_pkg::MODE_DEST_OVER: r_d = sat_s(SW'(alpha_q) + SW'(t1_q));
          lbc_pkg::MODE_DEST_OUT:                          r_d = t2_q;
          lbc_pkg::MODE_XOR:       r_d = sat_s((s_q + HALF_S) >> N);
          lbc_pkg::MODE_ADD, lbc_pkg::MODE_SATURATE:
            r_d = sat_s(SW'(a_q) + SW'(alpha_q));
          lbc_pkg::MODE_OVER, [lbc_pkg::MODE_MULTIPLY:lbc_pkg::MODE_EXCLUSION]:
            r_d = sat_s(SW'(a_q) + SW'(t2_q));
          default:                                         r_d = alpha_q;
        endcase
        ch_d    = '0;
        state_d = chan_start(mode_q);
      end
      ST_F1: begin
        state_d = ST_N1;
        case (mode_q) inside
          lbc_pkg::MODE_MULTIPLY: begin
            mul_a = MW'(xc);
            mul_b = yc;
            f_d   = rnd_v;
          end
          lbc_pkg::MODE_SCREEN: begin
            mul_a = MW'(xc);
            mul_b = yc;
            f_d   = sat_s(SW'(xc) + SW'(yc) - SW'(rnd_v));
          end
          lbc_pkg::MODE_OVERLAY, lbc_pkg::MODE_HARD_LIGHT: begin
            cond  = (mode_q == lbc_pkg::MODE_OVERLAY) ? (yc <= HALF) : (xc < HALF);
            mul_a = cond ? MW'(xc) : MW'(xi);
            mul_b = cond ? yc : yi;
            f_d   = cond ? h : (ONE - h);
          end
          lbc_pkg::MODE_DARKEN:     f_d = (xc < yc) ? xc : yc;
          lbc_pkg::MODE_LIGHTEN:    f_d = (xc > yc) ? xc : yc;
          lbc_pkg::MODE_DIFFERENCE: f_d = (yc > xc) ? (yc - xc) : (xc - yc);
          lbc_pkg::MODE_COLOR_DODGE: begin
            if (xc < ONE) begin
              ds_req.start = 1'b1;
              ds_num       = (SW'(yc) << N) + SW'(xi >> 1);
              ds_den       = xi;
              state_d      = ST_FDIV;
            end else begin
              f_d = ONE;
            end
          end
          lbc_pkg::MODE_COLOR_BURN: begin
            if (xc != '0) begin
              ds_req.start = 1'b1;
              ds_num       = (SW'(yi) << N) + SW'(xc >> 1);
              ds_den       = xc;
              state_d      = ST_FDIV;
            end else begin
              f_d = '0;
            end
          end
          lbc_pkg::MODE_SOFT_LIGHT: begin
            if (xc <= HALF) begin
              mul_a   = ONE_M - (MW'(xc) << 1);
              mul_b   = yc;
              u_d     = rnd_w[UW-1:0];
              state_d = ST_F2;
            end else if (yc <= QUARTER) begin
              mul_a   = TWELVE_M - (MW'(yc) << 4);
              mul_b   = yc;
              u_d     = rnd_w[UW-1:0];
              state_d = ST_F2;
            end else begin
              ds_req.start   = 1'b1;
              ds_req.is_sqrt = 1'b1;
              ds_num         = SW'(yc) << N;
              state_d        = ST_FDIV;
            end
          end
          default: begin
            mul_a = MW'(xc);
            mul_b = yc;
            f_d   = sat_s(SW'(ex_w));
          end
        endcase
      end
      ST_F2: begin
        if (xc <= HALF) begin
          mul_a   = MW'(u_q);
          mul_b   = yi;
          f_d     = (t > yc) ? '0 : (yc - t);
          state_d = ST_N1;
        end else begin
          mul_a   = FOUR_M - MW'(u_q);
          mul_b   = yc;
          g_d     = rnd_v;
          state_d = ST_F3;
        end
      end
      ST_F3: begin
        mul_a   = MW'(e);
        mul_b   = dv;
        f_d     = gge ? sat_s(SW'(yc) + SW'(t)) : ((t > yc) ? '0 : (yc - t));
        state_d = ST_N1;
      end
      ST_FDIV: begin
        if (ds_done) begin
          case (mode_q)
            lbc_pkg::MODE_COLOR_DODGE: begin
              f_d     = ds_res;
              state_d = ST_N1;
            end
            lbc_pkg::MODE_COLOR_BURN: begin
              f_d     = ONE - ds_res;
              state_d = ST_N1;
            end
            default: begin
              g_d     = ds_res;
              state_d = ST_F3;
            end
          endcase
        end
      end
      ST_N1: begin
        case (mode_q) inside
          lbc_pkg::MODE_OVER, lbc_pkg::MODE_ATOP, lbc_pkg::MODE_ADD: mul_a = MW'(a_q);
          lbc_pkg::MODE_DEST_ATOP:                                  mul_a = MW'(bi);
          lbc_pkg::MODE_SATURATE: mul_a = (a_q < bi) ? MW'(a_q) : MW'(bi);
          default:                                                  mul_a = MW'(t1_q);
        endcase
        mul_b   = xc;
        s_d     = SW'(prod);
        state_d = ST_N2;
      end
      ST_N2: begin
        case (mode_q) inside
          lbc_pkg::MODE_ATOP: mul_a = MW'(ai);
          lbc_pkg::MODE_DEST_OVER, lbc_pkg::MODE_DEST_ATOP, lbc_pkg::MODE_ADD,
          lbc_pkg::MODE_SATURATE: mul_a = MW'(alpha_q);
          default:            mul_a = MW'(t2_q);
        endcase
        mul_b   = yc;
        s_d     = s_q + SW'(prod);
        state_d = is_pdf(mode_q) ? ST_N3 : ST_NFIN;
      end
      ST_N3: begin
        mul_a   = MW'(t3_q);
        mul_b   = f_q;
        s_d     = s_q + SW'(prod);
        state_d = ST_NFIN;
      end
      ST_NFIN: begin
        if (is_round(mode_q)) begin
          v_d     = sat_s((s_q + HALF_S) >> N);
          state_d = ST_WR;
        end else begin
          ds_req.start = 1'b1;
          ds_num       = s_q + SW'(r_q >> 1);
          ds_den       = r_q;
          state_d      = ST_VDIV;
        end
      end
      ST_VDIV: begin
        if (ds_done) begin
          v_d     = ds_res;
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        if (is_div(mode_q) || is_round(mode_q)) begin
          wval = v_q;
        end else begin
          case (mode_q) inside
            lbc_pkg::MODE_CLEAR:                                        wval = ai;
            lbc_pkg::MODE_SOURCE, lbc_pkg::MODE_IN, lbc_pkg::MODE_OUT: wval = xc;
            default:                                                    wval = yc;
          endcase
        end
        col_d[ch_q] = (r_q == '0) ? '0 : wval;
        if (ch_q == LAST_CH) begin
          alpha_d = r_q;
          ch_d    = '0;
          state_d = last_q ? ST_OWAIT : ST_IDLE;
        end else begin
          ch_d    = ch_q + CHW'(1);
          state_d = chan_start(mode_q);
        end
      end
      ST_OWAIT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          ch_d    = '0;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        mul_a       = MW'(yc);
        mul_b       = alpha_q;
        out_d[ch_q] = FW'(rnd_w);
        if (ch_q == LAST_CH) begin
          m_valid_d   = 1'b1;
          out_alpha_d = FW'(alpha_q);
          ch_d        = '0;
          state_d     = ST_IDLE;
        end else begin
          ch_d = ch_q + CHW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ch_q      <= '0;
      m_valid_q <= 1'b0;
      alpha_q   <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        col_q[c] <= '0;
      end
    end else begin
      state_q   <= state_d;
      ch_q      <= ch_d;
      m_valid_q <= m_valid_d;
      alpha_q   <= alpha_d;
      col_q     <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    out_q       <= out_d;
    a_q         <= a_d;
    mode_q      <= mode_d;
    last_q      <= last_d;
    t1_q        <= t1_d;
    t2_q        <= t2_d;
    t3_q        <= t3_d;
    r_q         <= r_d;
    s_q         <= s_d;
    u_q         <= u_d;
    g_q         <= g_d;
    f_q         <= f_d;
    v_q         <= v_d;
    out_alpha_q <= out_alpha_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;

  for (genvar c = 0; c < lbc_pkg::IN_CH; c++) begin : g_out
    if (c < CHANNELS) begin : g_used
      assign m_axis_tdata_o[c*FW +: FW] = out_q[c];
    end else begin : g_zero
      assign m_axis_tdata_o[c*FW +: FW] = '0;
    end
  end
  assign m_axis_tdata_o[lbc_pkg::IN_CH*FW +: FW] = out_alpha_q;

endmodule

### dv/tb_layer_blend_compositor.sv
`timescale 1ns / 1ps

module tb_layer_blend_compositor;

  typedef bit [63:0] u64_t;

  localparam int FB = 15;
  localparam u64_t ONE = 64'd1 << FB;
  localparam u64_t HALF = 64'd1 << (FB - 1);
  localparam u64_t QUARTER = 64'd1 << (FB - 2);

  class blend_scoreboard;
    u64_t acc_col[3];
    u64_t acc_a;
    bit [63:0] pixel_q[$];
    int errors;

    function u64_t qmul(u64_t a, u64_t b);
      return (a * b + HALF) >> FB;
    endfunction

    function u64_t sat1(u64_t v);
      return v > ONE ? ONE : v;
    endfunction

    function u64_t qdiv(u64_t num, u64_t den);
      if (den == 0) return 0;
      return sat1((num + den / 2) / den);
    endfunction

    function u64_t root_round(u64_t n);
      u64_t r;
      u64_t b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      if (n > r) r++;
      return r;
    endfunction

    function u64_t result_alpha(bit [4:0] m, u64_t a, u64_t b);
      longint s;
      case (m)
        lbc_pkg::MODE_CLEAR: return ONE - a;
        lbc_pkg::MODE_SOURCE, lbc_pkg::MODE_DEST_ATOP: return a;
        lbc_pkg::MODE_IN, lbc_pkg::MODE_DEST_IN: return qmul(a, b);
        lbc_pkg::MODE_OUT: return qmul(a, ONE - b);
        lbc_pkg::MODE_ATOP, lbc_pkg::MODE_DEST: return b;
        lbc_pkg::MODE_DEST_OVER: return sat1(b + qmul(a, ONE - b));
        lbc_pkg::MODE_DEST_OUT: return qmul(ONE - a, b);
        lbc_pkg::MODE_XOR: begin
          s = longint'(((a + b) << FB) + HALF - 2 * a * b) >>> FB;
          return s < 0 ? 0 : sat1(u64_t'(s));
        end
        lbc_pkg::MODE_ADD, lbc_pkg::MODE_SATURATE: return sat1(a + b);
        default: begin
          if (m == lbc_pkg::MODE_OVER ||
              (m >= lbc_pkg::MODE_MULTIPLY && m <= lbc_pkg::MODE_EXCLUSION))
            return sat1(a + qmul(b, ONE - a));
          return b;
        end
      endcase
    endfunction

    function u64_t mix_fn(bit [4:0] m, u64_t x, u64_t y);
      u64_t g, e, t;
      case (m)
        lbc_pkg::MODE_MULTIPLY: return qmul(x, y);
        lbc_pkg::MODE_SCREEN: return sat1(x + y - qmul(x, y));
        lbc_pkg::MODE_OVERLAY: begin
          if (y <= HALF) return sat1((2 * x * y + HALF) >> FB);
          return ONE - sat1((2 * (ONE - x) * (ONE - y) + HALF) >> FB);
        end
        lbc_pkg::MODE_DARKEN: return x < y ? x : y;
        lbc_pkg::MODE_LIGHTEN: return x > y ? x : y;
        lbc_pkg::MODE_COLOR_DODGE: return x < ONE ? qdiv(y << FB, ONE - x) : ONE;
        lbc_pkg::MODE_COLOR_BURN: return x > 0 ? ONE - qdiv((ONE - y) << FB, x) : 0;
        lbc_pkg::MODE_HARD_LIGHT: begin
          if (x < HALF) return sat1((2 * x * y + HALF) >> FB);
          return ONE - sat1((2 * (ONE - x) * (ONE - y) + HALF) >> FB);
        end
        lbc_pkg::MODE_SOFT_LIGHT: begin
          if (y <= QUARTER) g = qmul(4 * ONE - qmul(12 * ONE - 16 * y, y), y);
          else g = root_round(y << FB);
          if (x <= HALF) begin
            t = qmul(qmul(ONE - 2 * x, y), ONE - y);
            return t > y ? 0 : y - t;
          end
          e = 2 * x - ONE;
          if (g >= y) return sat1(y + qmul(e, g - y));
          t = qmul(e, y - g);
          return t > y ? 0 : y - t;
        end
        lbc_pkg::MODE_DIFFERENCE: return y > x ? y - x : x - y;
        default: return sat1((((x + y) << FB) - 2 * x * y + HALF) >> FB);
      endcase
    endfunction

    function void blend_layer(bit [4:0] m, u64_t x[3], u64_t a);
      u64_t b, r, t1, t2, t3, y, v;
      b = acc_a;
      r = result_alpha(m, a, b);
      for (int c = 0; c < 3; c++) begin
        y = acc_col[c];
        case (m)
          lbc_pkg::MODE_CLEAR: v = ONE - a;
          lbc_pkg::MODE_SOURCE, lbc_pkg::MODE_IN, lbc_pkg::MODE_OUT: v = x[c];
          lbc_pkg::MODE_OVER: v = qdiv(a * x[c] + qmul(b, ONE - a) * y, r);
          lbc_pkg::MODE_ATOP: v = sat1((x[c] * a + y * (ONE - a) + HALF) >> FB);
          lbc_pkg::MODE_DEST_OVER: v = qdiv(b * y + qmul(a, ONE - b) * x[c], r);
          lbc_pkg::MODE_DEST_ATOP: v = sat1((x[c] * (ONE - b) + y * b + HALF) >> FB);
          lbc_pkg::MODE_XOR: begin
            t1 = qmul(a, ONE - b);
            t2 = qmul(b, ONE - a);
            v = qdiv(t1 * x[c] + t2 * y, r);
          end
          lbc_pkg::MODE_ADD: v = qdiv(x[c] * a + y * b, r);
          lbc_pkg::MODE_SATURATE: begin
            t1 = a < ONE - b ? a : ONE - b;
            v = qdiv(t1 * x[c] + y * b, r);
          end
          default: begin
            if (m >= lbc_pkg::MODE_MULTIPLY && m <= lbc_pkg::MODE_EXCLUSION) begin
              t1 = qmul(ONE - b, a);
              t2 = qmul(ONE - a, b);
              t3 = qmul(a, b);
              v = qdiv(t1 * x[c] + t2 * y + t3 * mix_fn(m, x[c], y), r);
            end else begin
              v = y;
            end
          end
        endcase
        acc_col[c] = r == 0 ? 0 : v;
      end
      acc_a = r;
    endfunction

    function void note_layer(bit [63:0] data, bit [5:0] user, bit last);
      u64_t x[3];
      u64_t a;
      bit [63:0] px;
      a = sat1(u64_t'(data[63:48]));
      for (int c = 0; c < 3; c++) x[c] = sat1(u64_t'(data[16*c +: 16]));
      if (user[5]) begin
        for (int c = 0; c < 3; c++) acc_col[c] = x[c];
        acc_a = a;
      end else begin
        blend_layer(user[4:0], x, a);
      end
      if (last) begin
        for (int c = 0; c < 3; c++) px[16*c +: 16] = 16'(qmul(acc_col[c], acc_a));
        px[63:48] = acc_a[15:0];
        pixel_q.push_back(px);
      end
    endfunction

    task report(string what, int got, int want);
      $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_pixel(bit [63:0] data);
      bit [63:0] want;
      string names[4];
      names = '{"out_channel_0", "out_channel_1", "out_channel_2", "out_alpha"};
      if (pixel_q.size() == 0) begin
        report("unexpected transaction", data[63:48], 0);
        return;
      end
      want = pixel_q.pop_front();
      for (int f = 0; f < 4; f++)
        if (data[16*f +: 16] !== want[16*f +: 16])
          report(names[f], data[16*f +: 16], want[16*f +: 16]);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid_i = 0;
  logic s_axis_tready_o;
  logic [lbc_pkg::TDATA_W-1:0] s_axis_tdata_i = '0;
  logic [lbc_pkg::TUSER_W-1:0] s_axis_tuser_i = '0;
  logic s_axis_tlast_i = 0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 0;
  logic [lbc_pkg::TDATA_W-1:0] m_axis_tdata_o;

  blend_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_start = 0;
  logic hold_on = 0;

  always #1 clk_i = ~clk_i;

  layer_blend_compositor dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_pixel(m_axis_tdata_o);
    if (hold_on) begin
      m_axis_tready_i <= 0;
    end else begin
      m_axis_tready_i <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // long receiver stall
  initial begin
    wait (hold_start);
    @(posedge clk_i);
    hold_on <= 1;
    repeat (2000) @(posedge clk_i);
    hold_on <= 0;
  end

  function bit [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  task send_layer(bit [15:0] c0, bit [15:0] c1, bit [15:0] c2, bit [15:0] a,
                  bit [4:0] m, bit first, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= {a, c2, c1, c0};
    s_axis_tuser_i <= {first, m};
    s_axis_tlast_i <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_layer({a, c2, c1, c0}, {first, m}, last);
  endtask

  task send_random_pixel();
    int n;
    bit [4:0] m;
    n = $urandom_range(4);
    send_layer(pick_value(), pick_value(), pick_value(), pick_value(),
               5'($urandom_range(31)), 1, n == 0);
    for (int i = 1; i <= n; i++) begin
      if ($urandom_range(9) == 0) m = 5'($urandom_range(31));
      else m = 5'($urandom_range(lbc_pkg::MODE_EXCLUSION));
      send_layer(pick_value(), pick_value(), pick_value(), pick_value(), m, 0, i == n);
    end
  endtask

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int sent;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_layer(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, lbc_pkg::MODE_OVER, 1, 1);
    send_layer(16'd0, 16'd0, 16'd0, 16'd0, lbc_pkg::MODE_OVER, 1, 1);
    send_layer(16'd32768, 16'd100, 16'd16384, 16'd20000, lbc_pkg::MODE_OVER, 0, 1);
    send_layer(16'd12000, 16'd30000, 16'd8192, 16'd24000, lbc_pkg::MODE_OVER, 1, 0);
    for (int m = lbc_pkg::MODE_CLEAR; m <= lbc_pkg::MODE_EXCLUSION; m++)
      send_layer(16'($urandom_range(32768)), 16'd32768, 16'd0, 16'($urandom_range(32768)),
                 5'(m), 0, m == lbc_pkg::MODE_EXCLUSION);
    send_layer(16'd5000, 16'd6000, 16'd7000, 16'd32768, 5'd31, 0, 1);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = phase == 0 ? 6 : phase == 1 ? 75 : 0;
      recv_idle_pct = phase == 0 ? 75 : phase == 1 ? 6 : 0;
      if (phase == 2) hold_start = 1;
      sent = 0;
      while (sent < 375) begin
        if ($urandom_range(9) == 0) begin
          send_layer(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     5'($urandom_range(31)), 1'($urandom_range(1)), 1'($urandom_range(1)));
          sent++;
        end else begin
          send_random_pixel();
          sent += 3;
        end
      end
    end
    s_axis_tvalid_i <= 0;

    while (sb.pixel_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
